// ===== rtl/core/ttw_pkg.sv =====
package ttw_pkg;

    // Screen geometry.
    localparam int COLUMNS    = 80;
    localparam int ROWS       = 25;
    localparam int CELL_COUNT = COLUMNS * ROWS;
    localparam int ADDR_W     = $clog2(CELL_COUNT);
    localparam int CCOL_W     = $clog2(COLUMNS);
    localparam int CROW_W     = $clog2(ROWS);

    // Widths of the result fields.
    localparam int OUT_COL_W = 7;
    localparam int OUT_ROW_W = 5;

    localparam int CELL_W = 16;

    // Character codes.
    localparam logic [7:0] CODE_BLANK   = 8'h08;
    localparam logic [7:0] CODE_NEWLINE = 8'h0A;
    localparam logic [7:0] CODE_SPACE   = 8'h20;
    localparam logic [7:0] CODE_ERROR   = 8'h45;

    // Configuration registers.
    localparam int CFG_INDEX_W = 1;
    localparam logic [CFG_INDEX_W-1:0] CFG_DEFAULT_ATTR = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_ERROR_ATTR   = 1'd1;
    localparam logic [7:0] DEFAULT_ATTR_RESET = 8'd15;
    localparam logic [7:0] ERROR_ATTR_RESET   = 8'd244;

    typedef enum logic [1:0] {
        KIND_PUT   = 2'd0,
        KIND_BACK  = 2'd1,
        KIND_CLEAR = 2'd2,
        KIND_READ  = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ST_FILL,
        ST_IDLE,
        ST_EXEC,
        ST_RDWAIT,
        ST_SCROLL,
        ST_DONE
    } state_t;

    // A cell holds the attribute in the high byte and the character below it.
    function automatic logic [CELL_W-1:0] make_cell(input logic [7:0] at,
                                                    input logic [7:0] ch);
        make_cell = {at, ch};
    endfunction

endpackage

// ===== rtl/core/ttw_ram.sv =====
module ttw_ram #(
    parameter int DATA_W = 16,
    parameter int DEPTH  = 2000,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read data shows up the cycle after the address.
    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== rtl/core/text_terminal_writer_core.sv =====
// Character-cell text terminal. The screen is a single-port-write,
// single-port-read RAM of COLUMNS*ROWS cells (80x25), each cell an attribute
// byte over a character byte, plus a cursor held as a row and a column. Every
// input word is one command and produces exactly one output word that carries
// the cursor after the command, the cell read by a read command (zero
// otherwise) and the out-of-range flag. Commands are handled one at a time by
// a small sequencer around the screen RAM. A put-char, backspace or
// out-of-range command passes through accept, execute and hand-off states
// before the next acceptance, and a read adds a wait state because the
// RAM read data is registered. A put-char past the last cell or a newline
// on the bottom row scrolls the screen: every cell below the top row is
// copied one row up at one cell per cycle through the RAM, then the bottom
// row is zeroed once the last copy has been written. Clear screen sweeps
// the whole RAM with spaces in the default attribute. After reset the
// block runs a clearing pass over all CELL_COUNT cells that zeroes the
// screen; in_ready stays low until it is finished, while configuration
// writes are taken at any time. A finished output word waits in an output
// register, so the block accepts the next command while the previous word
// has not yet been taken.
module text_terminal_writer_core (
    input  logic                             clk,
    input  logic                             rst_n,

    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [ttw_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [7:0]                       cfg_data,

    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [1:0]                       kind,
    input  logic [7:0]                       char_code,
    input  logic [7:0]                       col,
    input  logic [7:0]                       row,
    input  logic                             use_cursor,
    input  logic [7:0]                       attr,

    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [ttw_pkg::OUT_COL_W-1:0]    cursor_col,
    output logic [ttw_pkg::OUT_ROW_W-1:0]    cursor_row,
    output logic [7:0]                       cell_char,
    output logic [7:0]                       cell_attr,
    output logic                             position_error
);

    import ttw_pkg::*;

    localparam logic [ADDR_W-1:0] COLS_A      = ADDR_W'(COLUMNS);
    localparam logic [ADDR_W-1:0] LAST_CELL   = ADDR_W'(CELL_COUNT - 1);
    localparam logic [ADDR_W-1:0] LAST_MOVE   = ADDR_W'(CELL_COUNT - COLUMNS - 1);
    localparam logic [ADDR_W-1:0] BOTTOM_CELL = ADDR_W'(CELL_COUNT - COLUMNS);

    // Sequencer and cursor state.
    state_t              state_reg, state_next;
    logic [CCOL_W-1:0]   cur_col_reg, cur_col_next;
    logic [CROW_W-1:0]   cur_row_reg, cur_row_next;
    logic [7:0]          default_attr_reg, default_attr_next;
    logic [7:0]          error_attr_reg, error_attr_next;
    logic [ADDR_W-1:0]   idx_reg, idx_next;
    logic [CELL_W-1:0]   fill_data_reg, fill_data_next;
    logic                fill_report_reg, fill_report_next;
    logic                mov_valid_reg, mov_valid_next;
    logic [ADDR_W-1:0]   mov_dst_reg, mov_dst_next;
    logic                out_valid_reg, out_valid_next;

    // Latched command.
    kind_t               kind_reg, kind_next;
    logic [7:0]          char_reg, char_next;
    logic [7:0]          col_in_reg, col_in_next;
    logic [7:0]          row_in_reg, row_in_next;
    logic                use_cursor_reg, use_cursor_next;
    logic [7:0]          attr_reg, attr_next;

    // Pending result and output word.
    logic [7:0]          res_char_reg, res_char_next;
    logic [7:0]          res_attr_reg, res_attr_next;
    logic                res_err_reg, res_err_next;
    logic [OUT_COL_W-1:0] out_col_reg, out_col_next;
    logic [OUT_ROW_W-1:0] out_row_reg, out_row_next;
    logic [7:0]          out_char_reg, out_char_next;
    logic [7:0]          out_attr_reg, out_attr_next;
    logic                out_err_reg, out_err_next;

    // Screen RAM ports.
    logic                wr_en;
    logic [ADDR_W-1:0]   wr_addr;
    logic [CELL_W-1:0]   wr_data;
    logic [ADDR_W-1:0]   rd_addr;
    logic [CELL_W-1:0]   rd_data;

    // Command decode.
    logic [7:0]          tgt_col;
    logic [7:0]          tgt_row;
    logic [7:0]          back_col;
    logic [7:0]          back_row;
    logic [ADDR_W-1:0]   pos;
    logic                outside;
    logic [8:0]          col_inc;
    logic [8:0]          row_inc;
    logic                out_free;

    ttw_ram #(
        .DATA_W (CELL_W),
        .DEPTH  (CELL_COUNT)
    ) u_screen (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == ST_IDLE);
    assign out_free  = !out_valid_reg || out_ready;

    // Backspace steps back one cell, wrapping to the end of the row above and
    // staying put at the home position.
    always_comb
    begin
        back_col = 8'(cur_col_reg);
        back_row = 8'(cur_row_reg);
        if (cur_col_reg != '0)
        begin
            back_col = 8'(cur_col_reg) - 8'd1;
        end
        else if (cur_row_reg != '0)
        begin
            back_col = 8'(COLUMNS - 1);
            back_row = 8'(cur_row_reg) - 8'd1;
        end
    end

    // One shared address calculation serves the in-range put-char, backspace and read commands.
    always_comb
    begin
        if (kind_reg == KIND_BACK)
        begin
            tgt_col = back_col;
            tgt_row = back_row;
        end
        else if (use_cursor_reg)
        begin
            tgt_col = 8'(cur_col_reg);
            tgt_row = 8'(cur_row_reg);
        end
        else
        begin
            tgt_col = col_in_reg;
            tgt_row = row_in_reg;
        end
        pos     = ADDR_W'(ADDR_W'(tgt_row) * COLS_A + ADDR_W'(tgt_col));
        col_inc = {1'b0, tgt_col} + 9'd1;
        row_inc = {1'b0, tgt_row} + 9'd1;
        outside = !use_cursor_reg &&
                  ((col_in_reg >= 8'(COLUMNS)) || (row_in_reg >= 8'(ROWS)));
    end

    always_comb
    begin
        state_next        = state_reg;
        cur_col_next      = cur_col_reg;
        cur_row_next      = cur_row_reg;
        default_attr_next = default_attr_reg;
        error_attr_next   = error_attr_reg;
        idx_next          = idx_reg;
        fill_data_next    = fill_data_reg;
        fill_report_next  = fill_report_reg;
        mov_valid_next    = 1'b0;
        mov_dst_next      = idx_reg;
        out_valid_next    = out_valid_reg;
        kind_next         = kind_reg;
        char_next         = char_reg;
        col_in_next       = col_in_reg;
        row_in_next       = row_in_reg;
        use_cursor_next   = use_cursor_reg;
        attr_next         = attr_reg;
        res_char_next     = res_char_reg;
        res_attr_next     = res_attr_reg;
        res_err_next      = res_err_reg;
        out_col_next      = out_col_reg;
        out_row_next      = out_row_reg;
        out_char_next     = out_char_reg;
        out_attr_next     = out_attr_reg;
        out_err_next      = out_err_reg;
        wr_en             = 1'b0;
        wr_addr           = pos;
        wr_data           = make_cell(attr_reg, char_reg);
        rd_addr           = pos;

        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_DEFAULT_ATTR: default_attr_next = cfg_data;
                CFG_ERROR_ATTR:   error_attr_next   = cfg_data;
                default:          ;
            endcase
        end

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        // A cell copied during a scroll is written the cycle after its read.
        if (mov_valid_reg)
        begin
            wr_en   = 1'b1;
            wr_addr = mov_dst_reg;
            wr_data = rd_data;
        end

        case (state_reg)
            ST_FILL:
            begin
                if (!mov_valid_reg)
                begin
                    wr_en   = 1'b1;
                    wr_addr = idx_reg;
                    wr_data = fill_data_reg;
                    if (idx_reg == LAST_CELL)
                    begin
                        state_next = fill_report_reg ? ST_DONE : ST_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_reg + ADDR_W'(1);
                    end
                end
            end

            ST_IDLE:
            begin
                if (in_valid)
                begin
                    kind_next       = kind_t'(kind);
                    char_next       = char_code;
                    col_in_next     = col;
                    row_in_next     = row;
                    use_cursor_next = use_cursor;
                    attr_next       = (attr == 8'd0) ? default_attr_reg : attr;
                    state_next      = ST_EXEC;
                end
            end

            ST_EXEC:
            begin
                res_char_next = 8'd0;
                res_attr_next = 8'd0;
                res_err_next  = 1'b0;
                state_next    = ST_DONE;
                case (kind_reg)
                    KIND_PUT:
                    begin
                        if (outside)
                        begin
                            wr_en        = 1'b1;
                            wr_addr      = LAST_CELL;
                            wr_data      = make_cell(error_attr_reg, CODE_ERROR);
                            res_err_next = 1'b1;
                        end
                        else if (char_reg == CODE_BLANK)
                        begin
                            wr_en        = 1'b1;
                            wr_data      = make_cell(attr_reg, CODE_SPACE);
                            cur_col_next = CCOL_W'(tgt_col);
                            cur_row_next = CROW_W'(tgt_row);
                        end
                        else
                        begin
                            wr_en = (char_reg != CODE_NEWLINE);
                            if ((char_reg != CODE_NEWLINE) && (col_inc != 9'(COLUMNS)))
                            begin
                                cur_col_next = CCOL_W'(col_inc);
                                cur_row_next = CROW_W'(tgt_row);
                            end
                            else if (row_inc == 9'(ROWS))
                            begin
                                // Ran past the bottom row: scroll one row.
                                cur_col_next = '0;
                                cur_row_next = CROW_W'(ROWS - 1);
                                idx_next     = '0;
                                state_next   = ST_SCROLL;
                            end
                            else
                            begin
                                cur_col_next = '0;
                                cur_row_next = CROW_W'(row_inc);
                            end
                        end
                    end

                    KIND_BACK:
                    begin
                        wr_en        = 1'b1;
                        wr_data      = make_cell(default_attr_reg, CODE_SPACE);
                        cur_col_next = CCOL_W'(tgt_col);
                        cur_row_next = CROW_W'(tgt_row);
                    end

                    KIND_CLEAR:
                    begin
                        cur_col_next     = '0;
                        cur_row_next     = '0;
                        idx_next         = '0;
                        fill_data_next   = make_cell(default_attr_reg, CODE_SPACE);
                        fill_report_next = 1'b1;
                        state_next       = ST_FILL;
                    end

                    KIND_READ:
                    begin
                        if (outside)
                        begin
                            res_err_next = 1'b1;
                        end
                        else
                        begin
                            state_next = ST_RDWAIT;
                        end
                    end

                    default: ;
                endcase
            end

            ST_RDWAIT:
            begin
                res_char_next = rd_data[7:0];
                res_attr_next = rd_data[15:8];
                state_next    = ST_DONE;
            end

            ST_SCROLL:
            begin
                rd_addr        = ADDR_W'(idx_reg + COLS_A);
                mov_valid_next = 1'b1;
                mov_dst_next   = idx_reg;
                if (idx_reg == LAST_MOVE)
                begin
                    idx_next         = BOTTOM_CELL;
                    fill_data_next   = '0;
                    fill_report_next = 1'b1;
                    state_next       = ST_FILL;
                end
                else
                begin
                    idx_next = idx_reg + ADDR_W'(1);
                end
            end

            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_col_next   = OUT_COL_W'(cur_col_reg);
                    out_row_next   = OUT_ROW_W'(cur_row_reg);
                    out_char_next  = res_char_reg;
                    out_attr_next  = res_attr_reg;
                    out_err_next   = res_err_reg;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            // Reset starts the clearing pass that zeroes the screen.
            state_reg        <= ST_FILL;
            cur_col_reg      <= '0;
            cur_row_reg      <= '0;
            default_attr_reg <= DEFAULT_ATTR_RESET;
            error_attr_reg   <= ERROR_ATTR_RESET;
            idx_reg          <= '0;
            fill_data_reg    <= '0;
            fill_report_reg  <= 1'b0;
            mov_valid_reg    <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            cur_col_reg      <= cur_col_next;
            cur_row_reg      <= cur_row_next;
            default_attr_reg <= default_attr_next;
            error_attr_reg   <= error_attr_next;
            idx_reg          <= idx_next;
            fill_data_reg    <= fill_data_next;
            fill_report_reg  <= fill_report_next;
            mov_valid_reg    <= mov_valid_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mov_dst_reg    <= mov_dst_next;
        kind_reg       <= kind_next;
        char_reg       <= char_next;
        col_in_reg     <= col_in_next;
        row_in_reg     <= row_in_next;
        use_cursor_reg <= use_cursor_next;
        attr_reg       <= attr_next;
        res_char_reg   <= res_char_next;
        res_attr_reg   <= res_attr_next;
        res_err_reg    <= res_err_next;
        out_col_reg    <= out_col_next;
        out_row_reg    <= out_row_next;
        out_char_reg   <= out_char_next;
        out_attr_reg   <= out_attr_next;
        out_err_reg    <= out_err_next;
    end

    assign out_valid      = out_valid_reg;
    assign cursor_col     = out_col_reg;
    assign cursor_row     = out_row_reg;
    assign cell_char      = out_char_reg;
    assign cell_attr      = out_attr_reg;
    assign position_error = out_err_reg;

    // An accepted word always moves the sequencer into execution.
    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> state_reg == ST_EXEC)
        else $error("accepted word did not start execution");

    // The cursor never leaves the screen.
    a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
        (32'(cur_col_reg) < COLUMNS) && (32'(cur_row_reg) < ROWS))
        else $error("cursor outside the screen");

    // A pending scroll copy only follows a scroll read.
    a_move_source: assert property (@(posedge clk) disable iff (!rst_n)
        mov_valid_reg |-> $past(state_reg) == ST_SCROLL)
        else $error("scroll copy without a scroll read");

    // A finished command hands its word to the output register.
    a_done_handoff: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DONE && out_free |=> out_valid_reg && state_reg == ST_IDLE)
        else $error("finished command did not reach the output");

endmodule
